FILE: hw/rtl/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg
// Types, constants and calendar helpers for the date difference pipeline.
// ----------------------------------------------------------------------------
package dd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 23;   // per-date day count, unsigned
  localparam int unsigned DiffW  = 23;   // signed result field
  localparam int unsigned ProdW  = 27;   // year * reciprocal
  localparam int unsigned QW     = 8;    // year / 100, at most 163
  localparam int unsigned LeapW  = 12;   // leap years before a year

  localparam int unsigned InDataW  = 48; // 46 field bits, byte padded
  localparam int unsigned OutDataW = 32; // 25 field bits, byte padded

  localparam logic [YearW-1:0] EpochYear   = YearW'(1970);
  // Leap years in 1..EpochYear-1
  localparam logic [LeapW-1:0] EpochLeaps  = LeapW'(477);
  // floor(x / 100) == (x * Recip100) >> Shift100 for any 14-bit x
  localparam logic [ProdW-1:0] Recip100    = ProdW'(5243);
  localparam int unsigned      Shift100    = 19;
  localparam logic [CountW-1:0] DaysPerYear = CountW'(365);
  localparam logic [YearW-1:0] Hundred     = YearW'(100);

  localparam logic signed [DiffW:0] DiffMax = (DiffW+1)'(4194303);
  localparam logic signed [DiffW:0] DiffMin = -(DiffW+1)'(4194304);

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [YearW-1:0]  prev_year;   // year - 1
    logic [YearW-1:0]  year_off;    // year - epoch
    logic              after_epoch;
    logic [ProdW-1:0]  prod_prev;   // prev_year * Recip100
    logic [ProdW-1:0]  prod_year;   // year * Recip100
  } s1_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic              leap;
    logic              after_epoch;
    logic [CountW-1:0] year_days;
    logic [LeapW-1:0]  leaps_before;
    logic              valid;
  } s2_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              valid;
  } s3_t;

  // Days before month m in a common year; months above twelve extend the rule.
  function automatic logic [8:0] month_prefix(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd395;
      default: r = 9'd426;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] r;
    if (m == MonthW'(2)) begin
      r = leap ? DayW'(29) : DayW'(28);
    end else if ((m[0] && m <= MonthW'(7)) || (!m[0] && m >= MonthW'(8))) begin
      r = DayW'(31);
    end else begin
      r = DayW'(30);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/date_difference_days.sv
// ----------------------------------------------------------------------------
// date_difference_days
// Signed day difference between two Gregorian dates, with validity flags.
// ----------------------------------------------------------------------------
// Throughput: one date pair per cycle; each stage stalls only while it is full
// and the stage after it cannot take its word.
// Reset: rst_ni clears the stage valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
// Stage 1: year - 1, year - epoch, and the reciprocal products for /100.
// Stage 2: quotients, leap flag, leap years before the year, 365 * years,
//          validity of day and month.
// Stage 3: per-date day count, with 1 January of the epoch year as day 1.
// Stage 4: difference of the two counts, saturated to 23 bits signed.
// Both dates run side by side in two identical lanes through stages 1 to 3.
// ----------------------------------------------------------------------------
module date_difference_days (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  input  logic [dd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [22:0] day_difference (signed), [23] first_valid, [24] second_valid,
  // [31:25] zero
  output logic [dd_pkg::OutDataW-1:0] m_axis_tdata
);

  // Stage valid bits and per-stage ready (a stage moves when it is empty or
  // the next one takes its word).
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Input unpacking, lane 0 is the first date, lane 1 the second.
  logic [dd_pkg::DayW-1:0]   in_day   [2];
  logic [dd_pkg::MonthW-1:0] in_month [2];
  logic [dd_pkg::YearW-1:0]  in_year  [2];

  assign in_day[0]   = s_axis_tdata[4:0];
  assign in_month[0] = s_axis_tdata[8:5];
  assign in_year[0]  = s_axis_tdata[22:9];
  assign in_day[1]   = s_axis_tdata[27:23];
  assign in_month[1] = s_axis_tdata[31:28];
  assign in_year[1]  = s_axis_tdata[45:32];

  dd_pkg::s1_t s1_d [2];
  dd_pkg::s1_t s1_q [2];
  dd_pkg::s2_t s2_d [2];
  dd_pkg::s2_t s2_q [2];
  dd_pkg::s3_t s3_d [2];
  dd_pkg::s3_t s3_q [2];

  for (genvar g = 0; g < 2; g++) begin : g_lane

    // ---- stage 1 ----
    always_comb begin
      s1_d[g].day         = in_day[g];
      s1_d[g].month       = in_month[g];
      s1_d[g].year        = in_year[g];
      s1_d[g].prev_year   = in_year[g] - dd_pkg::YearW'(1);
      s1_d[g].year_off    = in_year[g] - dd_pkg::EpochYear;
      s1_d[g].after_epoch = in_year[g] > dd_pkg::EpochYear;
      s1_d[g].prod_prev   = dd_pkg::ProdW'(s1_d[g].prev_year) * dd_pkg::Recip100;
      s1_d[g].prod_year   = dd_pkg::ProdW'(in_year[g]) * dd_pkg::Recip100;
    end

    // ---- stage 2 ----
    logic [dd_pkg::QW-1:0] q_prev;   // (year - 1) / 100
    logic [dd_pkg::QW-1:0] q_year;   // year / 100
    logic                  cent;     // year divisible by 100
    logic [dd_pkg::DayW-1:0] mlen;

    always_comb begin
      q_prev = s1_q[g].prod_prev[dd_pkg::Shift100 +: dd_pkg::QW];
      q_year = s1_q[g].prod_year[dd_pkg::Shift100 +: dd_pkg::QW];
      cent   = s1_q[g].year == dd_pkg::YearW'(q_year) * dd_pkg::Hundred;

      s2_d[g].day         = s1_q[g].day;
      s2_d[g].month       = s1_q[g].month;
      s2_d[g].after_epoch = s1_q[g].after_epoch;
      // 4/100/400 rule: divisible by 400 means a century with quotient % 4 == 0
      s2_d[g].leap        = (s1_q[g].year[1:0] == 2'd0) && (!cent || q_year[1:0] == 2'd0);
      s2_d[g].year_days   = dd_pkg::CountW'(s1_q[g].year_off) * dd_pkg::DaysPerYear;
      s2_d[g].leaps_before = dd_pkg::LeapW'(s1_q[g].prev_year[dd_pkg::YearW-1:2])
                           - dd_pkg::LeapW'(q_prev)
                           + dd_pkg::LeapW'(q_prev[dd_pkg::QW-1:2]);
      mlen                = dd_pkg::month_len(s1_q[g].month, s2_d[g].leap);
      s2_d[g].valid       = (s1_q[g].month != '0) && (s1_q[g].month <= dd_pkg::MonthW'(12))
                         && (s1_q[g].day != '0) && (s1_q[g].day <= mlen);
    end

    // ---- stage 3 ----
    logic [dd_pkg::CountW-1:0] whole_years;

    always_comb begin
      whole_years = s2_q[g].after_epoch
                  ? s2_q[g].year_days
                    + dd_pkg::CountW'(s2_q[g].leaps_before - dd_pkg::EpochLeaps)
                  : '0;
      s3_d[g].count = whole_years
                    + dd_pkg::CountW'(dd_pkg::month_prefix(s2_q[g].month))
                    + dd_pkg::CountW'(s2_q[g].leap && s2_q[g].month > dd_pkg::MonthW'(2))
                    + dd_pkg::CountW'(s2_q[g].day);
      s3_d[g].valid = s2_q[g].valid;
    end

    always_ff @(posedge clk_i) begin
      if (rdy1) s1_q[g] <= s1_d[g];
      if (rdy2) s2_q[g] <= s2_d[g];
      if (rdy3) s3_q[g] <= s3_d[g];
    end

  end

  // ---- stage 4: difference and saturation ----
  logic signed [dd_pkg::DiffW:0] diff;
  logic [dd_pkg::DiffW-1:0]      diff_sat;
  logic [dd_pkg::OutDataW-1:0]   out_d, out_q;

  always_comb begin
    diff = $signed({1'b0, s3_q[0].count}) - $signed({1'b0, s3_q[1].count});
    if (diff > dd_pkg::DiffMax) begin
      diff_sat = dd_pkg::DiffW'(dd_pkg::DiffMax);
    end else if (diff < dd_pkg::DiffMin) begin
      diff_sat = dd_pkg::DiffW'(dd_pkg::DiffMin);
    end else begin
      diff_sat = diff[dd_pkg::DiffW-1:0];
    end
    out_d = dd_pkg::OutDataW'({s3_q[1].valid, s3_q[0].valid, diff_sat});
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: dv/date_difference_days_checker.sv
// ----------------------------------------------------------------------------
// date_difference_days_checker
// Watches both stream channels of the day difference block, predicts the
// result word of every accepted date pair and compares it in order.
// ----------------------------------------------------------------------------
module date_difference_days_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [dd_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [dd_pkg::OutDataW-1:0] m_axis_tdata,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint StartYear = 1970;
  localparam longint GapMax    = 4194303;
  localparam longint GapMin    = -4194304;
  localparam int     ShownMax  = 10;

  typedef struct {
    logic signed [22:0] gap;
    logic               first_ok;
    logic               second_ok;
    logic [6:0]         pad;
  } day_gap_t;

  day_gap_t expected_gaps[$];
  int       mismatches;
  int       checked;

  function automatic bit is_leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // leap years in 1 .. y-1
  function automatic longint leap_years_before(input longint y);
    longint p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  // common-year days before month m; 13..15 continue the 30/31 pattern
  function automatic longint days_before_month(input logic [3:0] m);
    longint r;
    case (m)
      4'd2:    r = 31;
      4'd3:    r = 59;
      4'd4:    r = 90;
      4'd5:    r = 120;
      4'd6:    r = 151;
      4'd7:    r = 181;
      4'd8:    r = 212;
      4'd9:    r = 243;
      4'd10:   r = 273;
      4'd11:   r = 304;
      4'd12:   r = 334;
      4'd13:   r = 365;
      4'd14:   r = 395;
      4'd15:   r = 426;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic longint days_in_month(input logic [3:0] m, input longint y);
    longint r;
    if (m == 4'd2) begin
      r = is_leap_year(y) ? 29 : 28;
    end else if ((m[0] && m <= 4'd7) || (!m[0] && m >= 4'd8)) begin
      r = 31;
    end else begin
      r = 30;
    end
    return r;
  endfunction

  function automatic longint days_since_start(input logic [4:0] d, input logic [3:0] m,
                                              input logic [13:0] yr);
    longint y;
    longint n;
    y = longint'(yr);
    n = 0;
    // years before the start year add nothing
    if (y > StartYear) begin
      n += 365 * (y - StartYear) + leap_years_before(y) - leap_years_before(StartYear);
    end
    n += days_before_month(m);
    if (m > 4'd2 && is_leap_year(y)) begin
      n += 1;
    end
    n += longint'(d);
    return n;
  endfunction

  function automatic logic date_fits(input logic [4:0] d, input logic [3:0] m,
                                     input logic [13:0] yr);
    if (m < 4'd1 || m > 4'd12) begin
      return 1'b0;
    end
    if (d < 5'd1 || longint'(d) > days_in_month(m, longint'(yr))) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic day_gap_t predict_gap(input logic [dd_pkg::InDataW-1:0] w);
    day_gap_t r;
    longint   g;
    g = days_since_start(w[4:0], w[8:5], w[22:9]) - days_since_start(w[27:23], w[31:28], w[45:32]);
    if (g > GapMax) begin
      g = GapMax;
    end
    if (g < GapMin) begin
      g = GapMin;
    end
    r.gap       = g[22:0];
    r.first_ok  = date_fits(w[4:0], w[8:5], w[22:9]);
    r.second_ok = date_fits(w[27:23], w[31:28], w[45:32]);
    r.pad       = '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= ShownMax) begin
      $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
               $realtime, checked, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    day_gap_t want;
    day_gap_t got;
    if (!rst_ni) begin
      expected_gaps.delete();
      mismatches       = 0;
      checked          = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      // pop before push: a word entering now cannot leave in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        got.gap       = m_axis_tdata[22:0];
        got.first_ok  = m_axis_tdata[23];
        got.second_ok = m_axis_tdata[24];
        got.pad       = m_axis_tdata[31:25];
        if (expected_gaps.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMax) begin
            $display("%0t: result word 0x%08h with no date pair outstanding",
                     $realtime, m_axis_tdata);
          end
        end else begin
          want = expected_gaps.pop_front();
          if (got.gap !== want.gap) begin
            flag_mismatch("day_difference", longint'(want.gap), longint'(got.gap));
          end
          if (got.first_ok !== want.first_ok) begin
            flag_mismatch("first_valid", longint'(want.first_ok), longint'(got.first_ok));
          end
          if (got.second_ok !== want.second_ok) begin
            flag_mismatch("second_valid", longint'(want.second_ok), longint'(got.second_ok));
          end
          if (got.pad !== want.pad) begin
            flag_mismatch("padding", longint'(want.pad), longint'(got.pad));
          end
        end
        checked++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_gaps.push_back(predict_gap(s_axis_tdata));
      end
      mismatch_count_o <= mismatches;
      pending_o        <= expected_gaps.size();
      checked_o        <= checked;
    end
  end

endmodule

FILE: dv/date_difference_days_test.sv
// ----------------------------------------------------------------------------
// date_difference_days_test
// Drives date pairs into the day difference block: a directed set covering
// epoch, leap centuries, bad days and months, years outside the range and
// saturation, then random pairs under three idle profiles. A checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module date_difference_days_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int PhaseItems  = 680;     // random pairs per idle profile
  localparam int TailCycles  = 10;      // pipeline is 4 deep

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_date_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  logic [dd_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // [22:0] day_difference (signed), [23] first_valid, [24] second_valid,
  // [31:25] zero
  logic [dd_pkg::OutDataW-1:0] m_axis_tdata;

  int mismatch_count;
  int pending;
  int checked;
  int sent          = 0;
  int directed      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  date_difference_days dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  date_difference_days_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver back-pressure, one fresh draw per cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("date_difference_days_test NOT OK");
    $finish;
  end

  function automatic cal_date_t mk_date(input int d, input int m, input int y);
    cal_date_t r;
    r.day   = d[4:0];
    r.month = m[3:0];
    r.year  = y[13:0];
    return r;
  endfunction

  // Random date: mostly well-formed, some month-end and leap corners,
  // some out-of-range days and months, some raw bit patterns.
  function automatic cal_date_t pick_date();
    cal_date_t r;
    int        kind;
    int        yr;
    kind = $urandom_range(99);
    if (kind < 55) begin
      r = mk_date($urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(1970, 9999));
    end else if (kind < 72) begin
      // month ends; lean on February and century years for the 4/100/400 rule
      case ($urandom_range(2))
        0:       yr = $urandom_range(20, 99) * 100;
        1:       yr = $urandom_range(493, 2499) * 4;
        default: yr = $urandom_range(1970, 9999);
      endcase
      r = mk_date($urandom_range(28, 31),
                  ($urandom_range(1) == 0) ? 2 : $urandom_range(1, 12), yr);
    end else if (kind < 86) begin
      // day and month anywhere in their fields, years near the edges
      case ($urandom_range(7))
        0:       yr = 0;
        1:       yr = 1969;
        2:       yr = 1970;
        3:       yr = 9999;
        4:       yr = 10000;
        5:       yr = 16383;
        default: yr = $urandom_range(1970, 9999);
      endcase
      r = mk_date($urandom_range(31), $urandom_range(15), yr);
    end else begin
      r = mk_date($urandom_range(31), $urandom_range(15), $urandom_range(16383));
    end
    return r;
  endfunction

  // Offer one date pair and hold it until the block takes it.
  task automatic send_pair(input cal_date_t first, input cal_date_t second);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, second, first};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    sent++;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(input int count);
    cal_date_t a;
    cal_date_t b;
    int        pairing;
    repeat (count) begin
      a       = pick_date();
      pairing = $urandom_range(99);
      if (pairing < 15) begin
        b = a;                                   // zero difference
      end else if (pairing < 40) begin
        b = a;                                   // same year, month and day drawn anew
        b.month = 4'($urandom_range(1, 12));
        b.day   = 5'($urandom_range(1, 31));
      end else begin
        b = pick_date();
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    cal_date_t dir_first[$];
    cal_date_t dir_second[$];

    // epoch against itself, full range both ways, a month boundary
    dir_first.push_back(mk_date(1, 1, 1970));     dir_second.push_back(mk_date(1, 1, 1970));
    dir_first.push_back(mk_date(31, 12, 9999));   dir_second.push_back(mk_date(1, 1, 1970));
    dir_first.push_back(mk_date(1, 1, 1970));     dir_second.push_back(mk_date(31, 12, 9999));
    dir_first.push_back(mk_date(31, 1, 1970));    dir_second.push_back(mk_date(1, 2, 1970));
    // leap rule: divisible by 400, by 100 only, by 4 only, not at all
    dir_first.push_back(mk_date(29, 2, 2000));    dir_second.push_back(mk_date(1, 3, 2000));
    dir_first.push_back(mk_date(29, 2, 2100));    dir_second.push_back(mk_date(28, 2, 2100));
    dir_first.push_back(mk_date(29, 2, 2024));    dir_second.push_back(mk_date(29, 2, 2023));
    dir_first.push_back(mk_date(31, 12, 2400));   dir_second.push_back(mk_date(1, 1, 2401));
    // year before the epoch: only the month prefix and day count
    dir_first.push_back(mk_date(29, 2, 1900));    dir_second.push_back(mk_date(15, 6, 1969));
    dir_first.push_back(mk_date(1, 3, 1968));     dir_second.push_back(mk_date(1, 1, 0));
    // month zero and months above twelve
    dir_first.push_back(mk_date(5, 0, 2000));     dir_second.push_back(mk_date(5, 1, 2000));
    dir_first.push_back(mk_date(31, 13, 2004));   dir_second.push_back(mk_date(30, 14, 2005));
    dir_first.push_back(mk_date(31, 15, 2001));   dir_second.push_back(mk_date(1, 15, 1970));
    // day zero and day too large for its month
    dir_first.push_back(mk_date(0, 7, 2010));     dir_second.push_back(mk_date(31, 4, 2010));
    dir_first.push_back(mk_date(31, 6, 3000));    dir_second.push_back(mk_date(31, 7, 3000));
    dir_first.push_back(mk_date(30, 2, 2000));    dir_second.push_back(mk_date(31, 9, 2000));
    // years above 9999 and saturation of the difference
    dir_first.push_back(mk_date(1, 1, 10000));    dir_second.push_back(mk_date(31, 12, 9999));
    dir_first.push_back(mk_date(31, 15, 16383));  dir_second.push_back(mk_date(0, 0, 0));
    dir_first.push_back(mk_date(0, 0, 0));        dir_second.push_back(mk_date(31, 15, 16383));
    dir_first.push_back(mk_date(1, 1, 13500));    dir_second.push_back(mk_date(1, 1, 1970));
    dir_first.push_back(mk_date(31, 12, 9999));   dir_second.push_back(mk_date(31, 12, 9999));

    // reset, once
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed set, no idling
    foreach (dir_first[i]) begin
      send_pair(dir_first[i], dir_second[i]);
    end
    directed = sent;
    drain_results();

    // sender sparse-ish, receiver stalls a lot
    send_idle_pct = 28;
    recv_idle_pct = 52;
    run_random(PhaseItems);
    drain_results();

    // the other way round
    send_idle_pct = 52;
    recv_idle_pct = 28;
    run_random(PhaseItems);
    drain_results();

    // back to back, no stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PhaseItems);
    drain_results();

    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d date pairs (%0d directed), %0d results checked", sent, directed, checked);
    $display("three idle profiles: sender 28/receiver 52, 52/28, and none; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("date_difference_days_test OK");
    end else begin
      $display("date_difference_days_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dd_pkg.sv
hw/rtl/date_difference_days.sv
dv/date_difference_days_checker.sv
dv/date_difference_days_test.sv
